/* sv/pdd_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, angle constants, the arctangent table and stage payload types.
package pdd_pkg;

   localparam int PORT_COORD_W = 24;
   localparam int NORM_W       = 30;
   localparam int SQ1_W        = 62;
   localparam int SQ2_W        = 32;
   localparam int DIV_W        = 48;
   localparam int QUO_W        = 16;
   localparam int COS_W        = 16;
   localparam int CRD_W        = 34;
   localparam int CRD_PRESHIFT = 12;
   localparam int ANG_FRAC     = 16;
   localparam int DIP_W        = 14;
   localparam int DIR_W        = 16;
   localparam int ATAN_LEN     = 24;

   localparam int QUARTER_TURN = 9000;
   localparam int HALF_TURN    = 18000;
   localparam int FULL_TURN    = 36000;
   localparam int COS_MAX      = 32767;
   localparam int ANG_ROUND    = 32768;

   // atan(2^-i) in units of 2^-16 hundredth of a degree
   localparam logic [29:0] ATAN_TAB [0:ATAN_LEN-1] = '{
      30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507, 30'd23437865,
      30'd11730358,  30'd5866610,   30'd2933484,  30'd1466764,  30'd733385,
      30'd366693,    30'd183346,    30'd91673,    30'd45837,    30'd22918,
      30'd11459,     30'd5730,      30'd2865,     30'd1432,     30'd716,
      30'd358,       30'd179,       30'd90,       30'd45
   };

   typedef struct packed {
      logic                   kind;
      logic                   deg;
      logic [2:0]             neg;
      logic [2:0][NORM_W-1:0] norm;
   } norm_side_type;

   typedef struct packed {
      logic       kind;
      logic       deg;
      logic [2:0] neg;
   } div_side_type;

   typedef struct packed {
      logic                  kind;
      logic                  deg;
      logic [2:0][COS_W-1:0] cs;
   } cos_side_type;

   typedef struct packed {
      logic                  kind;
      logic                  deg;
      logic [2:0][COS_W-1:0] cs;
      logic [1:0]            y_zero;
      logic [1:0]            x_zero;
   } crd_side_type;

endpackage

/* sv/pdd_sqrt_cell.sv */
`timescale 1ns / 1ps
// One digit stage of the pipelined integer square root.
module pdd_sqrt_cell #(
   parameter int W  = 62,
   parameter int K  = 30,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          src_valid,
   input  logic [W-1:0]  src_rad,
   input  logic [W-1:0]  src_root,
   input  logic [SW-1:0] src_side,
   output logic          dst_valid,
   output logic [W-1:0]  dst_rad,
   output logic [W-1:0]  dst_root,
   output logic [SW-1:0] dst_side
);
   localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};
   localparam logic [W-1:0] BIT = ONE << (2 * K);

   logic          valid_ff;
   logic [W-1:0]  rad_ff, rad_in, root_ff, root_in, trial;
   logic [SW-1:0] side_ff;

   assign trial = src_root + BIT;

   always_comb begin
      if (src_rad >= trial) begin
         rad_in  = src_rad - trial;
         root_in = (src_root >> 1) + BIT;
      end else begin
         rad_in  = src_rad;
         root_in = src_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      side_ff <= src_side;
   end

   assign dst_valid = valid_ff;
   assign dst_rad   = rad_ff;
   assign dst_root  = root_ff;
   assign dst_side  = side_ff;
endmodule

/* sv/pdd_div_cell.sv */
`timescale 1ns / 1ps
// One quotient-bit stage of the three-lane restoring divider.
module pdd_div_cell
   import pdd_pkg::*;
#(
   parameter int B  = 15,
   parameter int SW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  src_valid,
   input  logic [2:0][DIV_W-1:0] src_rem,
   input  logic [DIV_W-1:0]      src_den,
   input  logic [2:0][QUO_W-1:0] src_quo,
   input  logic [SW-1:0]         src_side,
   output logic                  dst_valid,
   output logic [2:0][DIV_W-1:0] dst_rem,
   output logic [DIV_W-1:0]      dst_den,
   output logic [2:0][QUO_W-1:0] dst_quo,
   output logic [SW-1:0]         dst_side
);
   logic                  valid_ff;
   logic [2:0][DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]      den_ff, shifted;
   logic [2:0][QUO_W-1:0] quo_ff, quo_in;
   logic [SW-1:0]         side_ff;

   assign shifted = src_den << B;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rem_in[l] = src_rem[l];
         quo_in[l] = src_quo[l];
         if (src_rem[l] >= shifted) begin
            rem_in[l]    = src_rem[l] - shifted;
            quo_in[l][B] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= src_den;
      quo_ff  <= quo_in;
      side_ff <= src_side;
   end

   assign dst_valid = valid_ff;
   assign dst_rem   = rem_ff;
   assign dst_den   = den_ff;
   assign dst_quo   = quo_ff;
   assign dst_side  = side_ff;
endmodule

/* sv/pdd_cordic_cell.sv */
`timescale 1ns / 1ps
// One vectoring iteration of the two-lane CORDIC arctangent.
module pdd_cordic_cell
   import pdd_pkg::*;
#(
   parameter int I  = 0,
   parameter int SW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  src_valid,
   input  logic [1:0][CRD_W-1:0] src_x,
   input  logic [1:0][CRD_W-1:0] src_y,
   input  logic [1:0][CRD_W-1:0] src_z,
   input  logic [SW-1:0]         src_side,
   output logic                  dst_valid,
   output logic [1:0][CRD_W-1:0] dst_x,
   output logic [1:0][CRD_W-1:0] dst_y,
   output logic [1:0][CRD_W-1:0] dst_z,
   output logic [SW-1:0]         dst_side
);
   localparam logic signed [CRD_W-1:0] ANG = CRD_W'(ATAN_TAB[I]);

   logic                  valid_ff;
   logic [1:0][CRD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [SW-1:0]         side_ff;
   logic signed [CRD_W-1:0] xv [2];
   logic signed [CRD_W-1:0] yv [2];
   logic signed [CRD_W-1:0] zv [2];
   logic signed [CRD_W-1:0] dx [2];
   logic signed [CRD_W-1:0] dy [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         xv[l] = $signed(src_x[l]);
         yv[l] = $signed(src_y[l]);
         zv[l] = $signed(src_z[l]);
         // shift the magnitude so both signs truncate toward zero
         dx[l] = (yv[l] < 0) ? -((-yv[l]) >>> I) : (yv[l] >>> I);
         dy[l] = (xv[l] < 0) ? -((-xv[l]) >>> I) : (xv[l] >>> I);
         if (yv[l] >= 0) begin
            x_in[l] = xv[l] + dx[l];
            y_in[l] = yv[l] - dy[l];
            z_in[l] = zv[l] + ANG;
         end else begin
            x_in[l] = xv[l] - dx[l];
            y_in[l] = yv[l] + dy[l];
            z_in[l] = zv[l] - ANG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= src_side;
   end

   assign dst_valid = valid_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_z     = z_ff;
   assign dst_side  = side_ff;
endmodule

/* sv/plane_dip_and_dip_direction.sv */
`timescale 1ns / 1ps
// Top level: dip, dip direction and unit normal of a plane through three points.
//
//   channel   | handshake            | beat moves
//   ----------+----------------------+-----------------------------------------
//   request   | start / busy         | kind bit and three 3-D points
//   response  | rsp_valid (strobe)   | dip, dip direction, cosines, degenerate
//
// A new beat is taken every cycle; busy stays low.
// Each result passes through the 31-stage and 16-stage square-root chains, the
// 16-stage divider and the CORDIC.
// Synchronous reset empties the pipeline; beats in flight are dropped.
// The receiver cannot stall; the pipeline never holds.
module plane_dip_and_dip_direction
   import pdd_pkg::*;
#(
   parameter int COORD_BITS    = 24,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_plane_kind,
   input  logic signed [PORT_COORD_W-1:0] req_apex_x,
   input  logic signed [PORT_COORD_W-1:0] req_apex_y,
   input  logic signed [PORT_COORD_W-1:0] req_apex_z,
   input  logic signed [PORT_COORD_W-1:0] req_second_x,
   input  logic signed [PORT_COORD_W-1:0] req_second_y,
   input  logic signed [PORT_COORD_W-1:0] req_second_z,
   input  logic signed [PORT_COORD_W-1:0] req_third_x,
   input  logic signed [PORT_COORD_W-1:0] req_third_y,
   input  logic signed [PORT_COORD_W-1:0] req_third_z,
   output logic                    rsp_valid,
   output logic [DIP_W-1:0]        rsp_dip_angle,
   output logic [DIR_W-1:0]        rsp_dip_direction,
   output logic signed [COS_W-1:0] rsp_cosine_x,
   output logic signed [COS_W-1:0] rsp_cosine_y,
   output logic signed [COS_W-1:0] rsp_cosine_z,
   output logic                    rsp_degenerate
);
   localparam int C      = COORD_BITS;
   localparam int DW     = C + 1;
   localparam int PW     = 2 * DW;
   localparam int CW     = PW + 1;
   localparam int LW     = $clog2(CW + 1);
   localparam int SQ1_N  = SQ1_W / 2;
   localparam int SQ2_N  = SQ2_W / 2;
   localparam int DIV_N  = QUO_W;
   localparam int LATENCY = 8 + SQ1_N + 1 + DIV_N + 3 + SQ2_N + 1 + CORDIC_STAGES + 2;
   localparam int NSW    = $bits(norm_side_type);
   localparam int DSW    = $bits(div_side_type);
   localparam int CSW    = $bits(cos_side_type);
   localparam int RSW    = $bits(crd_side_type);

   assign busy = 1'b0;

   // ---------------- stage 1: coordinates and edge vectors
   logic [31:0]           ext [9];
   logic signed [C-1:0]   pt  [9];
   logic signed [DW-1:0]  d1_ff [3];
   logic signed [DW-1:0]  d2_ff [3];
   logic                  v1_ff, kind1_ff;

   assign ext[0] = {{(32-PORT_COORD_W){1'b0}}, req_apex_x};
   assign ext[1] = {{(32-PORT_COORD_W){1'b0}}, req_apex_y};
   assign ext[2] = {{(32-PORT_COORD_W){1'b0}}, req_apex_z};
   assign ext[3] = {{(32-PORT_COORD_W){1'b0}}, req_second_x};
   assign ext[4] = {{(32-PORT_COORD_W){1'b0}}, req_second_y};
   assign ext[5] = {{(32-PORT_COORD_W){1'b0}}, req_second_z};
   assign ext[6] = {{(32-PORT_COORD_W){1'b0}}, req_third_x};
   assign ext[7] = {{(32-PORT_COORD_W){1'b0}}, req_third_y};
   assign ext[8] = {{(32-PORT_COORD_W){1'b0}}, req_third_z};

   always_comb begin
      for (int i = 0; i < 9; i++) pt[i] = $signed(ext[i][C-1:0]);
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         d1_ff[j] <= DW'(pt[3+j]) - DW'(pt[j]);
         d2_ff[j] <= DW'(pt[6+j]) - DW'(pt[j]);
      end
      kind1_ff <= req_plane_kind;
   end

   // ---------------- stage 2: partial products of the cross product
   logic signed [PW-1:0] prod_ff [6];
   logic                 v2_ff, kind2_ff;

   always_ff @(posedge clock) begin
      prod_ff[0] <= d1_ff[1] * d2_ff[2];
      prod_ff[1] <= d1_ff[2] * d2_ff[1];
      prod_ff[2] <= d1_ff[2] * d2_ff[0];
      prod_ff[3] <= d1_ff[0] * d2_ff[2];
      prod_ff[4] <= d1_ff[0] * d2_ff[1];
      prod_ff[5] <= d1_ff[1] * d2_ff[0];
      kind2_ff   <= kind1_ff;
   end

   // ---------------- stage 3: cross product
   logic signed [CW-1:0] cross_ff [3];
   logic                 v3_ff, kind3_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) cross_ff[k] <= CW'(prod_ff[2*k]) - CW'(prod_ff[2*k+1]);
      kind3_ff <= kind2_ff;
   end

   // ---------------- stage 4: sign and magnitude
   logic [CW-1:0] mag4_ff [3];
   logic [2:0]    neg4_ff;
   logic          v4_ff, kind4_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         neg4_ff[k] <= cross_ff[k][CW-1];
         mag4_ff[k] <= cross_ff[k][CW-1] ? CW'(-cross_ff[k]) : CW'(cross_ff[k]);
      end
      kind4_ff <= kind3_ff;
   end

   // ---------------- stage 5: leading-one position of the largest magnitude
   logic [CW-1:0] any_bits;
   logic [LW-1:0] len_in, len_ff;
   logic [CW-1:0] mag5_ff [3];
   logic [2:0]    neg5_ff;
   logic          v5_ff, kind5_ff, deg5_ff;

   always_comb begin
      any_bits = mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      len_in   = '0;
      for (int i = 0; i < CW; i++) begin
         if (any_bits[i]) len_in = LW'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      mag5_ff  <= mag4_ff;
      neg5_ff  <= neg4_ff;
      kind5_ff <= kind4_ff;
      deg5_ff  <= (any_bits == '0);
   end

   // ---------------- stage 6: normalize the largest magnitude into [2^29, 2^30)
   logic [NORM_W-1:0] norm_in [3];
   logic [NORM_W-1:0] norm_ff [3];
   logic [2:0]        neg6_ff;
   logic              v6_ff, kind6_ff, deg6_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (len_ff > LW'(NORM_W)) begin
            norm_in[k] = NORM_W'(mag5_ff[k] >> (len_ff - LW'(NORM_W)));
         end else begin
            norm_in[k] = NORM_W'(mag5_ff[k]) << (LW'(NORM_W) - len_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      norm_ff  <= norm_in;
      neg6_ff  <= neg5_ff;
      kind6_ff <= kind5_ff;
      deg6_ff  <= deg5_ff;
   end

   // ---------------- stage 7: squares
   logic [2*NORM_W-1:0] sq_ff [3];
   logic [NORM_W-1:0]   norm7_ff [3];
   logic [2:0]          neg7_ff;
   logic                v7_ff, kind7_ff, deg7_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) sq_ff[k] <= norm_ff[k] * norm_ff[k];
      norm7_ff <= norm_ff;
      neg7_ff  <= neg6_ff;
      kind7_ff <= kind6_ff;
      deg7_ff  <= deg6_ff;
   end

   // ---------------- stage 8: sum of squares
   logic [SQ1_W-1:0] sum1_ff;
   norm_side_type    ns8_ff;
   logic             v8_ff;

   always_ff @(posedge clock) begin
      sum1_ff     <= SQ1_W'(sq_ff[0]) + SQ1_W'(sq_ff[1]) + SQ1_W'(sq_ff[2]);
      ns8_ff.kind <= kind7_ff;
      ns8_ff.deg  <= deg7_ff;
      ns8_ff.neg  <= neg7_ff;
      for (int k = 0; k < 3; k++) ns8_ff.norm[k] <= norm7_ff[k];
   end

   // valid chain of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   // ---------------- square root of the normal length
   logic             s1_valid [SQ1_N+1];
   logic [SQ1_W-1:0] s1_rad   [SQ1_N+1];
   logic [SQ1_W-1:0] s1_root  [SQ1_N+1];
   logic [NSW-1:0]   s1_side  [SQ1_N+1];

   assign s1_valid[0] = v8_ff;
   assign s1_rad[0]   = sum1_ff;
   assign s1_root[0]  = '0;
   assign s1_side[0]  = ns8_ff;

   for (genvar g = 0; g < SQ1_N; g++) begin : g_sqrt1
      pdd_sqrt_cell #(.W(SQ1_W), .K(SQ1_N - 1 - g), .SW(NSW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (s1_valid[g]),
         .src_rad   (s1_rad[g]),
         .src_root  (s1_root[g]),
         .src_side  (s1_side[g]),
         .dst_valid (s1_valid[g+1]),
         .dst_rad   (s1_rad[g+1]),
         .dst_root  (s1_root[g+1]),
         .dst_side  (s1_side[g+1])
      );
   end

   // ---------------- stage 9: divider operands
   norm_side_type         ns_out;
   logic [2:0][DIV_W-1:0] num_ff;
   logic [DIV_W-1:0]      den_ff;
   div_side_type          ds9_ff;
   logic                  v9_ff;

   assign ns_out = s1_side[SQ1_N];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         num_ff[k] <= (DIV_W'(ns_out.norm[k]) << 16) + DIV_W'(s1_root[SQ1_N][SQ1_N-1:0]);
      end
      den_ff      <= DIV_W'(s1_root[SQ1_N][SQ1_N-1:0]) << 1;
      ds9_ff.kind <= ns_out.kind;
      ds9_ff.deg  <= ns_out.deg;
      ds9_ff.neg  <= ns_out.neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= s1_valid[SQ1_N];
      end
   end

   // ---------------- divider chain
   logic                  dv_valid [DIV_N+1];
   logic [2:0][DIV_W-1:0] dv_rem   [DIV_N+1];
   logic [DIV_W-1:0]      dv_den   [DIV_N+1];
   logic [2:0][QUO_W-1:0] dv_quo   [DIV_N+1];
   logic [DSW-1:0]        dv_side  [DIV_N+1];

   assign dv_valid[0] = v9_ff;
   assign dv_rem[0]   = num_ff;
   assign dv_den[0]   = den_ff;
   assign dv_quo[0]   = '0;
   assign dv_side[0]  = ds9_ff;

   for (genvar g = 0; g < DIV_N; g++) begin : g_div
      pdd_div_cell #(.B(DIV_N - 1 - g), .SW(DSW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (dv_valid[g]),
         .src_rem   (dv_rem[g]),
         .src_den   (dv_den[g]),
         .src_quo   (dv_quo[g]),
         .src_side  (dv_side[g]),
         .dst_valid (dv_valid[g+1]),
         .dst_rem   (dv_rem[g+1]),
         .dst_den   (dv_den[g+1]),
         .dst_quo   (dv_quo[g+1]),
         .dst_side  (dv_side[g+1])
      );
   end

   // ---------------- stage 10: signed cosines
   div_side_type          ds_out;
   logic [2:0][COS_W-1:0] cs_in, cs10_ff;
   logic [2:0][COS_W-1:0] cmag_in, cmag_ff;
   logic                  v10_ff, kind10_ff, deg10_ff;

   assign ds_out = dv_side[DIV_N];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (ds_out.neg[k]) begin
            cs_in[k]   = COS_W'(-dv_quo[DIV_N][k]);
            cmag_in[k] = dv_quo[DIV_N][k];
         end else if (dv_quo[DIV_N][k] > COS_W'(COS_MAX)) begin
            cs_in[k]   = COS_W'(COS_MAX);
            cmag_in[k] = COS_W'(COS_MAX);
         end else begin
            cs_in[k]   = dv_quo[DIV_N][k];
            cmag_in[k] = dv_quo[DIV_N][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      cs10_ff   <= cs_in;
      cmag_ff   <= cmag_in;
      kind10_ff <= ds_out.kind;
      deg10_ff  <= ds_out.deg;
   end

   // ---------------- stage 11: horizontal squares
   logic [SQ2_W-1:0]      hsq_ff [2];
   logic [2:0][COS_W-1:0] cs11_ff;
   logic                  v11_ff, kind11_ff, deg11_ff;

   always_ff @(posedge clock) begin
      hsq_ff[0] <= cmag_ff[0] * cmag_ff[0];
      hsq_ff[1] <= cmag_ff[1] * cmag_ff[1];
      cs11_ff   <= cs10_ff;
      kind11_ff <= kind10_ff;
      deg11_ff  <= deg10_ff;
   end

   // ---------------- stage 12: horizontal sum
   logic [SQ2_W-1:0] sum2_ff;
   cos_side_type     cs12_ff;
   logic             v12_ff;

   always_ff @(posedge clock) begin
      sum2_ff      <= hsq_ff[0] + hsq_ff[1];
      cs12_ff.kind <= kind11_ff;
      cs12_ff.deg  <= deg11_ff;
      cs12_ff.cs   <= cs11_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
      end else begin
         v10_ff <= dv_valid[DIV_N];
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
      end
   end

   // ---------------- square root of the horizontal length
   logic             s2_valid [SQ2_N+1];
   logic [SQ2_W-1:0] s2_rad   [SQ2_N+1];
   logic [SQ2_W-1:0] s2_root  [SQ2_N+1];
   logic [CSW-1:0]   s2_side  [SQ2_N+1];

   assign s2_valid[0] = v12_ff;
   assign s2_rad[0]   = sum2_ff;
   assign s2_root[0]  = '0;
   assign s2_side[0]  = cs12_ff;

   for (genvar g = 0; g < SQ2_N; g++) begin : g_sqrt2
      pdd_sqrt_cell #(.W(SQ2_W), .K(SQ2_N - 1 - g), .SW(CSW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (s2_valid[g]),
         .src_rad   (s2_rad[g]),
         .src_root  (s2_root[g]),
         .src_side  (s2_side[g]),
         .dst_valid (s2_valid[g+1]),
         .dst_rad   (s2_rad[g+1]),
         .dst_root  (s2_root[g+1]),
         .dst_side  (s2_side[g+1])
      );
   end

   // ---------------- stage 13: CORDIC operands (lane 0 dip, lane 1 direction)
   cos_side_type          c2_out;
   logic [2:0][COS_W-1:0] am;
   logic [1:0][COS_W-1:0] ly, lx;
   logic [1:0][CRD_W-1:0] cx13_ff, cy13_ff;
   crd_side_type          rs13_ff;
   logic                  v13_ff;

   assign c2_out = s2_side[SQ2_N];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         am[k] = c2_out.cs[k][COS_W-1] ? COS_W'(-c2_out.cs[k]) : c2_out.cs[k];
      end
      ly[0] = s2_root[SQ2_N][COS_W-1:0];
      lx[0] = am[2];
      ly[1] = am[0];
      lx[1] = am[1];
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         cx13_ff[l]        <= CRD_W'(lx[l]) << CRD_PRESHIFT;
         cy13_ff[l]        <= CRD_W'(ly[l]) << CRD_PRESHIFT;
         rs13_ff.y_zero[l] <= (ly[l] == '0);
         rs13_ff.x_zero[l] <= (lx[l] == '0);
      end
      rs13_ff.kind <= c2_out.kind;
      rs13_ff.deg  <= c2_out.deg;
      rs13_ff.cs   <= c2_out.cs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v13_ff <= 1'b0;
      end else begin
         v13_ff <= s2_valid[SQ2_N];
      end
   end

   // ---------------- CORDIC chain
   logic                  cr_valid [CORDIC_STAGES+1];
   logic [1:0][CRD_W-1:0] cr_x     [CORDIC_STAGES+1];
   logic [1:0][CRD_W-1:0] cr_y     [CORDIC_STAGES+1];
   logic [1:0][CRD_W-1:0] cr_z     [CORDIC_STAGES+1];
   logic [RSW-1:0]        cr_side  [CORDIC_STAGES+1];

   assign cr_valid[0] = v13_ff;
   assign cr_x[0]     = cx13_ff;
   assign cr_y[0]     = cy13_ff;
   assign cr_z[0]     = '0;
   assign cr_side[0]  = rs13_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      pdd_cordic_cell #(.I(g), .SW(RSW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (cr_valid[g]),
         .src_x     (cr_x[g]),
         .src_y     (cr_y[g]),
         .src_z     (cr_z[g]),
         .src_side  (cr_side[g]),
         .dst_valid (cr_valid[g+1]),
         .dst_x     (cr_x[g+1]),
         .dst_y     (cr_y[g+1]),
         .dst_z     (cr_z[g+1]),
         .dst_side  (cr_side[g+1])
      );
   end

   // ---------------- stage 14: round angles to hundredths of a degree
   crd_side_type            rs_out;
   logic signed [CRD_W-1:0] zs [2];
   logic signed [CRD_W-1:0] zr [2];
   logic [DIP_W-1:0]        ang_in [2];
   logic [DIP_W-1:0]        ang_ff [2];
   crd_side_type            rs14_ff;
   logic                    v14_ff;

   assign rs_out = cr_side[CORDIC_STAGES];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         zs[l] = $signed(cr_z[CORDIC_STAGES][l]);
         zr[l] = (zs[l] + CRD_W'(ANG_ROUND)) >>> ANG_FRAC;
         priority if (rs_out.y_zero[l]) begin
            ang_in[l] = '0;
         end else if (rs_out.x_zero[l]) begin
            ang_in[l] = DIP_W'(QUARTER_TURN);
         end else if (zs[l] < 0) begin
            ang_in[l] = '0;
         end else if (zr[l] > CRD_W'(QUARTER_TURN)) begin
            ang_in[l] = DIP_W'(QUARTER_TURN);
         end else begin
            ang_in[l] = zr[l][DIP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      ang_ff  <= ang_in;
      rs14_ff <= rs_out;
   end

   // ---------------- stage 15: quadrant offsets and result register
   logic signed [17:0]       temp, tt, dd_raw, dd;
   logic                     lin, cx_neg, cy_neg, cz_neg;
   logic [DIP_W-1:0]         dip;
   logic                     rsp_valid_ff;
   logic [DIP_W-1:0]         dip_ff;
   logic [DIR_W-1:0]         dir_ff;
   logic [2:0][COS_W-1:0]    cos_ff;
   logic                     deg_ff;

   always_comb begin
      lin    = rs14_ff.kind;
      cx_neg = rs14_ff.cs[0][COS_W-1];
      cy_neg = rs14_ff.cs[1][COS_W-1];
      cz_neg = rs14_ff.cs[2][COS_W-1];
      temp   = ((!cz_neg) != lin) ? 18'sd0 : 18'(HALF_TURN);
      tt     = (cx_neg != cy_neg) ? -18'(ang_ff[1]) : 18'(ang_ff[1]);
      if (rs14_ff.cs[1] == '0) begin
         dd_raw = 18'(QUARTER_TURN) + temp + (cx_neg ? 18'sd0 : 18'(HALF_TURN));
      end else begin
         dd_raw = (cy_neg ? 18'(HALF_TURN) : 18'(FULL_TURN)) + tt + temp;
      end
      dd = (dd_raw >= 18'(FULL_TURN)) ? dd_raw - 18'(FULL_TURN) : dd_raw;
      // flat plane or vertical lineation has no direction
      if (ang_ff[0] == '0) dd = '0;
      dip = lin ? DIP_W'(QUARTER_TURN) - ang_ff[0] : ang_ff[0];
   end

   always_ff @(posedge clock) begin
      if (rs14_ff.deg) begin
         dip_ff <= '0;
         dir_ff <= '0;
         cos_ff <= '0;
      end else begin
         dip_ff <= dip;
         dir_ff <= dd[DIR_W-1:0];
         cos_ff <= rs14_ff.cs;
      end
      deg_ff <= rs14_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v14_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v14_ff       <= cr_valid[CORDIC_STAGES];
         rsp_valid_ff <= v14_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dip_angle     = dip_ff;
   assign rsp_dip_direction = dir_ff;
   assign rsp_cosine_x      = $signed(cos_ff[0]);
   assign rsp_cosine_y      = $signed(cos_ff[1]);
   assign rsp_cosine_z      = $signed(cos_ff[2]);
   assign rsp_degenerate    = deg_ff;
endmodule

/* sv/pdd_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the plane dip block and their binding to the top level.
module pdd_checker
   import pdd_pkg::*;
#(
   parameter int LAT = 94
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [DIP_W-1:0]        rsp_dip_angle,
   input logic [DIR_W-1:0]        rsp_dip_direction,
   input logic signed [COS_W-1:0] rsp_cosine_x,
   input logic signed [COS_W-1:0] rsp_cosine_y,
   input logic signed [COS_W-1:0] rsp_cosine_z,
   input logic                    rsp_degenerate
);
   // every result beat traces back to one accepted request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start, LAT) && !$past(busy, LAT)))
      else $error("result beat without matching request");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_dip_angle == '0 && rsp_dip_direction == '0
         && rsp_cosine_x == '0 && rsp_cosine_y == '0 && rsp_cosine_z == '0)
      else $error("degenerate result with nonzero fields");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_dip_angle <= DIP_W'(QUARTER_TURN)
         && rsp_dip_direction < DIR_W'(FULL_TURN))
      else $error("angle out of range");

   a_vertical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate && rsp_cosine_z == '0
         |-> rsp_dip_angle == '0 || rsp_dip_angle == DIP_W'(QUARTER_TURN))
      else $error("vertical normal with oblique dip");
endmodule

bind plane_dip_and_dip_direction pdd_checker #(.LAT(LATENCY)) u_pdd_checker (.*);
